[hdl/spectral_noise_estimator_macros.svh]
// assertion macros shared by the spectral noise estimator
`ifndef SPECTRAL_NOISE_ESTIMATOR_MACROS_SVH
`define SPECTRAL_NOISE_ESTIMATOR_MACROS_SVH

// expr must hold at every clock edge out of reset
`define SNE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define SNE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/sne_pkg.sv]
// types and constants of the spectral noise estimator
package sne_pkg;

  localparam int BIN_W      = 10;
  localparam int PWR_W      = 32;
  localparam int PROB_W     = 16;
  localparam int THR_W      = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int PIPE_DEPTH = 7;

  // q1.15 coefficients
  localparam logic [14:0] C_SMOOTH_OLD = 15'd22938;
  localparam logic [14:0] C_SMOOTH_NEW = 15'd9830;
  localparam logic [14:0] C_GAMMA      = 15'd32702;
  localparam logic [8:0]  C_MIN_GAIN   = 9'd328;
  // minimum gain times beta, folded into one constant
  localparam logic [23:0] C_GAIN_BETA  = 24'd8598192;
  localparam logic [14:0] C_P_OLD      = 15'd6554;
  // presence weight times one, scaled by 2^15
  localparam logic [31:0] C_P_NEW_ONE  = 32'd858980352;
  localparam logic [15:0] C_AD         = 16'd32440;
  localparam logic [15:0] Q15_ONE      = 16'd32768;
  localparam logic [15:0] ROUND15      = 16'd16384;
  localparam logic [29:0] ROUND30      = 30'd536870912;

  // reset values of the configuration registers
  localparam logic [BIN_W-1:0] RST_LOW_LAST   = 10'd43;
  localparam logic [BIN_W-1:0] RST_HIGH_FIRST = 10'd128;
  localparam logic [THR_W-1:0] RST_THR_LOW    = 16'd512;
  localparam logic [THR_W-1:0] RST_THR_MID    = 16'd512;
  localparam logic [THR_W-1:0] RST_THR_HIGH   = 16'd768;

  typedef enum logic [2:0] {
    REG_LOW_LAST   = 3'd0,
    REG_HIGH_FIRST = 3'd1,
    REG_THR_LOW    = 3'd2,
    REG_THR_MID    = 3'd3,
    REG_THR_HIGH   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [BIN_W-1:0] low_last;
    logic [BIN_W-1:0] high_first;
    logic [THR_W-1:0] thr_low;
    logic [THR_W-1:0] thr_mid;
    logic [THR_W-1:0] thr_high;
  } cfg_t;

  typedef struct packed {
    logic [PWR_W-1:0]  smoothed;
    logic [PWR_W-1:0]  minimum;
    logic [PROB_W-1:0] presence;
    logic [PWR_W-1:0]  noise;
  } entry_t;

  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic [PWR_W-1:0]  noise;
    logic [PROB_W-1:0] presence;
    logic              speech;
    logic              frame_end;
  } result_t;

endpackage

[hdl/sne_cfg_regs.sv]
// apb register file holding band limits and ratio thresholds
module sne_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sne_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sne_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sne_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output sne_pkg::cfg_t                    cfg
);

  sne_pkg::cfg_t    cfg_r;
  sne_pkg::reg_idx_t idx;

  assign idx    = sne_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_last   <= sne_pkg::RST_LOW_LAST;
      cfg_r.high_first <= sne_pkg::RST_HIGH_FIRST;
      cfg_r.thr_low    <= sne_pkg::RST_THR_LOW;
      cfg_r.thr_mid    <= sne_pkg::RST_THR_MID;
      cfg_r.thr_high   <= sne_pkg::RST_THR_HIGH;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        sne_pkg::REG_LOW_LAST:   cfg_r.low_last   <= pwdata[sne_pkg::BIN_W-1:0];
        sne_pkg::REG_HIGH_FIRST: cfg_r.high_first <= pwdata[sne_pkg::BIN_W-1:0];
        sne_pkg::REG_THR_LOW:    cfg_r.thr_low    <= pwdata[sne_pkg::THR_W-1:0];
        sne_pkg::REG_THR_MID:    cfg_r.thr_mid    <= pwdata[sne_pkg::THR_W-1:0];
        sne_pkg::REG_THR_HIGH:   cfg_r.thr_high   <= pwdata[sne_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sne_pkg::REG_LOW_LAST:   prdata = 32'(cfg_r.low_last);
      sne_pkg::REG_HIGH_FIRST: prdata = 32'(cfg_r.high_first);
      sne_pkg::REG_THR_LOW:    prdata = 32'(cfg_r.thr_low);
      sne_pkg::REG_THR_MID:    prdata = 32'(cfg_r.thr_mid);
      sne_pkg::REG_THR_HIGH:   prdata = 32'(cfg_r.thr_high);
      default:                 prdata = '0;
    endcase
  end

endmodule

[hdl/sne_state_ram.sv]
// per-bin state memory, one write and one registered read per cycle
module sne_state_ram #(
  parameter int BINS = 1024
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [$clog2(BINS)-1:0] rd_addr,
  output sne_pkg::entry_t       rd_entry,
  input  logic                  wr_en,
  input  logic [$clog2(BINS)-1:0] wr_addr,
  input  sne_pkg::entry_t       wr_entry
);

  sne_pkg::entry_t mem [BINS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

[hdl/sne_update_pipe.sv]
// seven-stage update pipeline for smoothed power, minimum, presence and noise
module sne_update_pipe #(
  parameter int BINS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          accept,
  input  logic [sne_pkg::BIN_W-1:0]     in_bin,
  input  logic [sne_pkg::PWR_W-1:0]     in_y,
  input  logic                          in_fe,
  input  sne_pkg::cfg_t                 cfg,
  input  sne_pkg::entry_t               rd_entry,
  output logic                          busy,
  output logic                          wr_en,
  output logic [$clog2(BINS)-1:0]       wr_addr,
  output sne_pkg::entry_t               wr_entry,
  output logic                          res_valid,
  output sne_pkg::result_t              res
);

  localparam int D  = sne_pkg::PIPE_DEPTH;
  localparam int AW = $clog2(BINS);

  // items in flight
  logic [D:1]                   v_r;
  logic [sne_pkg::BIN_W-1:0]    bin_r [1:D];
  logic [D:1]                   fe_r;
  logic [D:1]                   ok_r;

  // stage 1
  logic [31:0] y1_r;
  logic [15:0] thr1_r;
  // stage 2
  logic [46:0] ma2_r, mb2_r, mg2_r;
  logic [55:0] mk2_r;
  logic [28:0] mp2_r;
  logic [31:0] pm2_r, pd2_r, y2_r;
  logic [15:0] thr2_r;
  // stage 3
  logic [31:0] s3_r, pm3_r, pd3_r, y3_r;
  logic [15:0] p0_3_r, p1_3_r, thr3_r;
  logic [46:0] mg3_r;
  logic [55:0] mk3_r;
  // stage 4
  logic [47:0] u4_r;
  logic        lt4_r;
  logic [24:0] ar0_4_r, ar1_4_r;
  logic [31:0] s4_r, pd4_r, y4_r;
  logic [15:0] p0_4_r, p1_4_r, thr4_r;
  logic [55:0] mk4_r;
  // stage 5
  logic        pos5_r, lt5_r;
  logic [62:0] diff5_r;
  logic [15:0] a0_5_r, a1_5_r, p0_5_r, p1_5_r, thr5_r;
  logic [31:0] s5_r, pd5_r, y5_r;
  // stage 6
  logic [31:0] m6_r, s6_r;
  logic [47:0] da0_6_r, db0_6_r, da1_6_r, db1_6_r;
  logic [15:0] p0_6_r, p1_6_r, thr6_r;
  // stage 7
  logic [47:0] prod7_r;
  logic [31:0] d0_7_r, d1_7_r, m7_r, s7_r;
  logic [15:0] p0_7_r, p1_7_r;

  // combinational next values
  logic        ok_nxt;
  logic [15:0] thr_nxt;
  logic [31:0] ps, pm, pd;
  logic [15:0] pp;
  logic [47:0] s_sum;
  logic [31:0] p0_sum, p1_sum;
  logic [47:0] u_nxt;
  logic [24:0] ar0_nxt, ar1_nxt;
  logic [62:0] sh;
  logic [25:0] ar0_sum, ar1_sum;
  logic [15:0] a0_nxt, a1_nxt;
  logic [63:0] rnd_sum;
  logic [33:0] rnd_q;
  logic [31:0] m_nxt;
  logic [15:0] w0, w1;
  logic [47:0] d0_sum, d1_sum;
  logic        ind;

  // hazard probe against every bin still in flight
  always_comb begin
    busy = 1'b0;
    for (int k = 1; k <= D; k++) begin
      if (v_r[k] && bin_r[k] == in_bin) begin
        busy = 1'b1;
      end
    end
  end

  // entry stage: range check and band threshold
  always_comb begin
    ok_nxt = {22'd0, in_bin} < 32'(BINS);
    if (in_bin >= cfg.high_first) begin
      thr_nxt = cfg.thr_high;
    end else if (in_bin <= cfg.low_last) begin
      thr_nxt = cfg.thr_low;
    end else begin
      thr_nxt = cfg.thr_mid;
    end
  end

  // out-of-range bins see all-zero state
  assign ps = ok_r[1] ? rd_entry.smoothed : '0;
  assign pm = ok_r[1] ? rd_entry.minimum  : '0;
  assign pp = ok_r[1] ? rd_entry.presence : '0;
  assign pd = ok_r[1] ? rd_entry.noise    : '0;

  always_comb begin
    s_sum  = 48'(ma2_r) + 48'(mb2_r) + 48'(sne_pkg::ROUND15);
    p0_sum = 32'(mp2_r) + 32'(sne_pkg::ROUND15);
    p1_sum = 32'(mp2_r) + sne_pkg::C_P_NEW_ONE + 32'(sne_pkg::ROUND15);

    u_nxt   = 48'(mg3_r) + 48'(sne_pkg::C_MIN_GAIN) * 48'(s3_r);
    ar0_nxt = 25'(sne_pkg::C_MIN_GAIN) * 25'(p0_3_r);
    ar1_nxt = 25'(sne_pkg::C_MIN_GAIN) * 25'(p1_3_r);

    sh      = {u4_r, 15'd0};
    ar0_sum = 26'(ar0_4_r) + 26'(sne_pkg::ROUND15);
    ar1_sum = 26'(ar1_4_r) + 26'(sne_pkg::ROUND15);
    a0_nxt  = sne_pkg::C_AD + 16'(ar0_sum[25:15]);
    a1_nxt  = sne_pkg::C_AD + 16'(ar1_sum[25:15]);

    rnd_sum = 64'(diff5_r) + 64'(sne_pkg::ROUND30);
    rnd_q   = rnd_sum[63:30];
    if (!lt5_r) begin
      m_nxt = s5_r;
    end else if (!pos5_r) begin
      m_nxt = '0;
    end else if (rnd_q[33:32] != 2'd0) begin
      m_nxt = '1;
    end else begin
      m_nxt = rnd_q[31:0];
    end
    w0 = sne_pkg::Q15_ONE - a0_5_r;
    w1 = sne_pkg::Q15_ONE - a1_5_r;

    d0_sum = da0_6_r + db0_6_r + 48'(sne_pkg::ROUND15);
    d1_sum = da1_6_r + db1_6_r + 48'(sne_pkg::ROUND15);

    ind = {8'd0, s7_r, 8'd0} > prod7_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[D-1:1], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bin_r[1] <= in_bin;
      fe_r[1]  <= in_fe;
      ok_r[1]  <= ok_nxt;
      y1_r     <= in_y;
      thr1_r   <= thr_nxt;
      for (int k = 2; k <= D; k++) begin
        bin_r[k] <= bin_r[k-1];
      end
      fe_r[D:2] <= fe_r[D-1:1];
      ok_r[D:2] <= ok_r[D-1:1];

      ma2_r  <= 47'(sne_pkg::C_SMOOTH_OLD) * 47'(ps);
      mb2_r  <= 47'(sne_pkg::C_SMOOTH_NEW) * 47'(y1_r);
      mg2_r  <= 47'(sne_pkg::C_GAMMA) * 47'(pm);
      mk2_r  <= 56'(sne_pkg::C_GAIN_BETA) * 56'(ps);
      mp2_r  <= 29'(sne_pkg::C_P_OLD) * 29'(pp);
      pm2_r  <= pm;
      pd2_r  <= pd;
      y2_r   <= y1_r;
      thr2_r <= thr1_r;

      s3_r   <= s_sum[46:15];
      p0_3_r <= p0_sum[30:15];
      p1_3_r <= p1_sum[30:15];
      mg3_r  <= mg2_r;
      mk3_r  <= mk2_r;
      pm3_r  <= pm2_r;
      pd3_r  <= pd2_r;
      y3_r   <= y2_r;
      thr3_r <= thr2_r;

      u4_r    <= u_nxt;
      lt4_r   <= pm3_r < s3_r;
      ar0_4_r <= ar0_nxt;
      ar1_4_r <= ar1_nxt;
      s4_r    <= s3_r;
      p0_4_r  <= p0_3_r;
      p1_4_r  <= p1_3_r;
      mk4_r   <= mk3_r;
      pd4_r   <= pd3_r;
      y4_r    <= y3_r;
      thr4_r  <= thr3_r;

      pos5_r  <= sh > 63'(mk4_r);
      diff5_r <= sh - 63'(mk4_r);
      lt5_r   <= lt4_r;
      a0_5_r  <= a0_nxt;
      a1_5_r  <= a1_nxt;
      s5_r    <= s4_r;
      p0_5_r  <= p0_4_r;
      p1_5_r  <= p1_4_r;
      pd5_r   <= pd4_r;
      y5_r    <= y4_r;
      thr5_r  <= thr4_r;

      // noise update for both outcomes of the ratio test
      m6_r    <= m_nxt;
      da0_6_r <= 48'(a0_5_r) * 48'(pd5_r);
      db0_6_r <= 48'(w0) * 48'(y5_r);
      da1_6_r <= 48'(a1_5_r) * 48'(pd5_r);
      db1_6_r <= 48'(w1) * 48'(y5_r);
      s6_r    <= s5_r;
      p0_6_r  <= p0_5_r;
      p1_6_r  <= p1_5_r;
      thr6_r  <= thr5_r;

      prod7_r <= 48'(thr6_r) * 48'(m6_r);
      d0_7_r  <= d0_sum[46:15];
      d1_7_r  <= d1_sum[46:15];
      m7_r    <= m6_r;
      s7_r    <= s6_r;
      p0_7_r  <= p0_6_r;
      p1_7_r  <= p1_6_r;
    end
  end

  assign wr_en             = adv && v_r[D] && ok_r[D];
  assign wr_addr           = AW'(bin_r[D]);
  assign wr_entry.smoothed = s7_r;
  assign wr_entry.minimum  = m7_r;
  assign wr_entry.presence = ind ? p1_7_r : p0_7_r;
  assign wr_entry.noise    = ind ? d1_7_r : d0_7_r;

  assign res_valid     = v_r[D];
  assign res.bin       = bin_r[D];
  assign res.noise     = wr_entry.noise;
  assign res.presence  = wr_entry.presence;
  assign res.speech    = ind;
  assign res.frame_end = fe_r[D];

endmodule

[hdl/spectral_noise_estimator.sv]
// top level of the spectral noise estimator
// Per-bin noise tracker for a streamed power spectrum (minimum tracking with a
// speech-presence controlled smoothing factor). Each item carries one bin's
// power in unsigned q16.16; the block reads that bin's smoothed power, local
// minimum, presence probability and noise estimate from one 112-bit wide state
// memory, updates them in a seven-stage pipeline and writes them back at the
// last stage, returning noise estimate, presence probability (q1.15) and the
// speech flag. Throughput is one item per clock while bins differ and the
// output register is not stalled. An item whose bin is still in the pipeline
// waits until that update has been written back, so a frame of distinct bins
// never stalls on its own. After reset the block zeroes every entry of the
// state memory and takes no item during that pass; register writes are taken
// throughout. Bins at or above BINS are processed against all-zero state and
// leave the memory untouched.
module spectral_noise_estimator #(
  parameter int BINS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input item channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sne_pkg::BIN_W-1:0]      in_bin_index,
  input  logic [sne_pkg::PWR_W-1:0]      in_power,
  input  logic                           in_frame_end,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sne_pkg::BIN_W-1:0]      out_bin,
  output logic [sne_pkg::PWR_W-1:0]      out_noise_estimate,
  output logic [sne_pkg::PROB_W-1:0]     out_presence_probability,
  output logic                           out_speech_detected,
  output logic                           out_frame_end,
  // apb configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sne_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sne_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sne_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int AW = $clog2(BINS);
  localparam logic [AW-1:0] CLR_LAST = AW'(BINS - 1);
  // presence bounds implied by the ratio test outcome
  localparam logic [15:0] P_MIN_SPEECH = 16'd26214;
  localparam logic [15:0] P_MAX_QUIET  = 16'd6554;

  sne_pkg::cfg_t    cfg;
  sne_pkg::entry_t  rd_entry;
  sne_pkg::entry_t  pipe_wr_entry;
  sne_pkg::entry_t  ram_wr_entry;
  sne_pkg::result_t res;
  sne_pkg::result_t out_res_r;

  logic            out_valid_r;
  logic            clr_active_r;
  logic [AW-1:0]   clr_addr_r;
  logic            adv;
  logic            accept;
  logic            busy;
  logic            pipe_wr_en;
  logic [AW-1:0]   pipe_wr_addr;
  logic            ram_wr_en;
  logic [AW-1:0]   ram_wr_addr;
  logic            res_valid;

  sne_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline moves unless a finished item meets a full, stalled output register
  assign adv      = !(out_valid_r && !out_ready && res_valid);
  assign in_ready = adv && !busy && !clr_active_r;
  assign accept   = in_valid && in_ready;

  // clearing pass: one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == CLR_LAST) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // memory write port shared by the clearing pass and the write-back stage
  assign ram_wr_en    = clr_active_r || pipe_wr_en;
  assign ram_wr_addr  = clr_active_r ? clr_addr_r : pipe_wr_addr;
  assign ram_wr_entry = clr_active_r ? '0 : pipe_wr_entry;

  sne_state_ram #(
    .BINS (BINS)
  ) u_ram (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (AW'(in_bin_index)),
    .rd_entry (rd_entry),
    .wr_en    (ram_wr_en),
    .wr_addr  (ram_wr_addr),
    .wr_entry (ram_wr_entry)
  );

  sne_update_pipe #(
    .BINS (BINS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .accept    (accept),
    .in_bin    (in_bin_index),
    .in_y      (in_power),
    .in_fe     (in_frame_end),
    .cfg       (cfg),
    .rd_entry  (rd_entry),
    .busy      (busy),
    .wr_en     (pipe_wr_en),
    .wr_addr   (pipe_wr_addr),
    .wr_entry  (pipe_wr_entry),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register, refilled in the same cycle it is drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_bin                  = out_res_r.bin;
  assign out_noise_estimate       = out_res_r.noise;
  assign out_presence_probability = out_res_r.presence;
  assign out_speech_detected      = out_res_r.speech;
  assign out_frame_end            = out_res_r.frame_end;

`include "spectral_noise_estimator_macros.svh"

  // no write-back may collide with the clearing pass
  `SNE_ASSERT_IMPLY(a_no_wb_in_clear, clr_active_r, !pipe_wr_en, "write-back during clear")
  // presence probability stays in q1.15 range
  `SNE_ASSERT_ALWAYS(a_p_range, !out_valid || out_presence_probability <= sne_pkg::Q15_ONE, "presence out of range")
  // speech flag and presence probability agree
  `SNE_ASSERT_IMPLY(a_p_speech, out_valid && out_speech_detected, out_presence_probability >= P_MIN_SPEECH, "low presence with speech")
  `SNE_ASSERT_IMPLY(a_p_quiet, out_valid && !out_speech_detected, out_presence_probability <= P_MAX_QUIET, "high presence without speech")
  // a retired item lands in the output register
  `SNE_ASSERT_NEXT(a_retire, adv && res_valid, out_valid && out_bin == $past(res.bin), "result lost at output")

endmodule

[tb/tb_spectral_noise_estimator.sv]
// self-checking testbench of the spectral noise estimator
module tb_spectral_noise_estimator;

  // bins kept by the block, one per value of the 10-bit bin field
  localparam int NUM_BINS = 1024;
  localparam int PERIOD = 20;
  // cycles without any item moving before the run is given up
  // (covers the clearing pass several times over)
  localparam int STALL_LIMIT = 5000;
  // extra cycles after the last result, somewhat beyond the pipeline depth
  localparam int SETTLE_CYCLES = sne_pkg::PIPE_DEPTH + 5;
  // register index that maps to no register
  localparam int UNMAPPED_REG = 7;

  // fixed-point weights of the recursion, q1.15
  localparam longint W_SMOOTH_KEEP = 22938;
  localparam longint W_SMOOTH_NEW = 9830;
  localparam longint W_GAMMA = 32702;
  localparam longint W_MIN_GAIN = 328;
  localparam longint W_BETA = 26214;
  localparam longint W_P_KEEP = 6554;
  localparam longint W_P_NEW = 26214;
  localparam longint W_AD = 32440;
  localparam longint W_AD_REST = 328;
  localparam longint Q15_UNITY = 32768;
  localparam longint PWR_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct {
    logic [sne_pkg::BIN_W-1:0] bin;
    logic [sne_pkg::PWR_W-1:0] power;
    logic frame_end;
  } bin_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [sne_pkg::BIN_W-1:0] in_bin_index = '0;
  logic [sne_pkg::PWR_W-1:0] in_power = '0;
  logic in_frame_end = 1'b0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic [sne_pkg::BIN_W-1:0] out_bin;
  logic [sne_pkg::PWR_W-1:0] out_noise_estimate;
  logic [sne_pkg::PROB_W-1:0] out_presence_probability;
  logic out_speech_detected;
  logic out_frame_end;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sne_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [sne_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [sne_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // predictor copy of the band registers, updated only while the block is idle
  logic [sne_pkg::BIN_W-1:0] cfg_low_last = sne_pkg::RST_LOW_LAST;
  logic [sne_pkg::BIN_W-1:0] cfg_high_first = sne_pkg::RST_HIGH_FIRST;
  logic [sne_pkg::THR_W-1:0] cfg_thr_low = sne_pkg::RST_THR_LOW;
  logic [sne_pkg::THR_W-1:0] cfg_thr_mid = sne_pkg::RST_THR_MID;
  logic [sne_pkg::THR_W-1:0] cfg_thr_high = sne_pkg::RST_THR_HIGH;

  // predictor copy of the per-bin state
  logic [sne_pkg::PWR_W-1:0] smooth_mem [NUM_BINS];
  logic [sne_pkg::PWR_W-1:0] minimum_mem [NUM_BINS];
  logic [sne_pkg::PROB_W-1:0] presence_mem [NUM_BINS];
  logic [sne_pkg::PWR_W-1:0] noise_mem [NUM_BINS];

  bin_item_t pending_bins [$];
  sne_pkg::result_t expected_results [$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int items_queued = 0;
  int results_checked = 0;
  int errors = 0;
  int idle_cycles = 0;

  spectral_noise_estimator #(
    .BINS(NUM_BINS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_bin_index(in_bin_index),
    .in_power(in_power),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bin(out_bin),
    .out_noise_estimate(out_noise_estimate),
    .out_presence_probability(out_presence_probability),
    .out_speech_detected(out_speech_detected),
    .out_frame_end(out_frame_end),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(PERIOD / 2) clk = ~clk;

  // round((wa*a + wb*b) / 2^15), weights add to one so the result fits 32 bits
  function automatic logic [31:0] blend_q15(input longint wa, input longint a,
                                            input longint wb, input longint b);
    longint acc;
    acc = wa * a + wb * b + 16384;
    return 32'(acc >>> 15);
  endfunction

  // one step of the noise tracker for an accepted bin; queues the result
  function automatic void predict_result(input logic [sne_pkg::BIN_W-1:0] bin,
                                         input logic [sne_pkg::PWR_W-1:0] pwr,
                                         input logic fe);
    longint prev_s, prev_m, prev_p, prev_d;
    longint y, s, m, p, a, d, t, thr;
    logic hit;
    sne_pkg::result_t want;
    prev_s = 0;
    prev_m = 0;
    prev_p = 0;
    prev_d = 0;
    y = longint'(pwr);
    // bins past the store see all-zero history
    if (bin < NUM_BINS) begin
      prev_s = longint'(smooth_mem[bin]);
      prev_m = longint'(minimum_mem[bin]);
      prev_p = longint'(presence_mem[bin]);
      prev_d = longint'(noise_mem[bin]);
    end
    s = blend_q15(W_SMOOTH_KEEP, prev_s, W_SMOOTH_NEW, y);
    // minimum tracking: follow slowly upward, snap down when power falls under it
    if (prev_m < s) begin
      t = W_GAMMA * prev_m * Q15_UNITY + W_MIN_GAIN * (s * Q15_UNITY - W_BETA * prev_s);
      if (t <= 0) begin
        m = 0;
      end else begin
        m = (t + (longint'(1) <<< 29)) >>> 30;
        if (m > PWR_MAX) m = PWR_MAX;
      end
    end else begin
      m = s;
    end
    // high band wins over low band where the two overlap
    if (bin >= cfg_high_first) begin
      thr = longint'(cfg_thr_high);
    end else if (bin <= cfg_low_last) begin
      thr = longint'(cfg_thr_low);
    end else begin
      thr = longint'(cfg_thr_mid);
    end
    // ratio test without division; a zero minimum passes any nonzero smoothed power
    hit = (s <<< 8) > thr * m;
    p = blend_q15(W_P_KEEP, prev_p, W_P_NEW, hit ? Q15_UNITY : 0);
    a = W_AD + ((W_AD_REST * p + 16384) >>> 15);
    d = blend_q15(a, prev_d, Q15_UNITY - a, y);
    if (bin < NUM_BINS) begin
      smooth_mem[bin] = 32'(s);
      minimum_mem[bin] = 32'(m);
      presence_mem[bin] = 16'(p);
      noise_mem[bin] = 32'(d);
    end
    want.bin = bin;
    want.noise = 32'(d);
    want.presence = 16'(p);
    want.speech = hit;
    want.frame_end = fe;
    expected_results.push_back(want);
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: bin %0d %s expected %h actual %h", $time, out_bin, what, want, got);
    end
  endfunction

  // driver: holds an item until taken, then pulls the next one or idles
  always @(posedge clk) begin : drive_bins
    bin_item_t next_bin;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_result(in_bin_index, in_power, in_frame_end);
      if (!in_valid || in_ready) begin
        if (pending_bins.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          next_bin = pending_bins.pop_front();
          in_valid <= 1'b1;
          in_bin_index <= next_bin.bin;
          in_power <= next_bin.power;
          in_frame_end <= next_bin.frame_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: every result is matched against the oldest prediction
  always @(posedge clk) begin : check_results
    sne_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual bin %0d noise %h",
                 $time, out_bin, out_noise_estimate);
      end else begin
        want = expected_results.pop_front();
        check_field("bin", 32'(want.bin), 32'(out_bin));
        check_field("noise", want.noise, out_noise_estimate);
        check_field("presence", 32'(want.presence), 32'(out_presence_probability));
        check_field("speech", 32'(want.speech), 32'(out_speech_detected));
        check_field("frame_end", 32'(want.frame_end), 32'(out_frame_end));
        results_checked++;
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [sne_pkg::BIN_W-1:0] bin,
                          input logic [sne_pkg::PWR_W-1:0] pwr, input logic fe);
    bin_item_t item;
    item.bin = bin;
    item.power = pwr;
    item.frame_end = fe;
    pending_bins.push_back(item);
    items_queued++;
  endtask

  // waits until every queued item has produced its result, then lets the pipe empty
  task automatic wait_drained();
    while (results_checked != items_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write followed by a read-back; junk in the unused data bits must be dropped
  task automatic write_reg(input int idx, input logic [31:0] value);
    logic [31:0] mask, data, readback;
    mask = (idx == sne_pkg::REG_LOW_LAST || idx == sne_pkg::REG_HIGH_FIRST) ?
           32'h0000_03FF : 32'h0000_FFFF;
    data = (value & mask) | ($urandom & ~mask);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sne_pkg::CFG_ADDR_W'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // register taken at this edge; turn straight into a read setup
    case (idx)
      sne_pkg::REG_LOW_LAST: cfg_low_last = data[sne_pkg::BIN_W-1:0];
      sne_pkg::REG_HIGH_FIRST: cfg_high_first = data[sne_pkg::BIN_W-1:0];
      sne_pkg::REG_THR_LOW: cfg_thr_low = data[sne_pkg::THR_W-1:0];
      sne_pkg::REG_THR_MID: cfg_thr_mid = data[sne_pkg::THR_W-1:0];
      sne_pkg::REG_THR_HIGH: cfg_thr_high = data[sne_pkg::THR_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx <= sne_pkg::REG_THR_HIGH && readback !== (data & mask)) begin
      errors++;
      $display("%0t: register %0d read back expected %h actual %h",
               $time, idx, data & mask, readback);
    end
  endtask

  task automatic set_bands(input logic [9:0] low_last, input logic [9:0] high_first,
                           input logic [15:0] thr_low, input logic [15:0] thr_mid,
                           input logic [15:0] thr_high);
    write_reg(sne_pkg::REG_LOW_LAST, 32'(low_last));
    write_reg(sne_pkg::REG_HIGH_FIRST, 32'(high_first));
    write_reg(sne_pkg::REG_THR_LOW, 32'(thr_low));
    write_reg(sne_pkg::REG_THR_MID, 32'(thr_mid));
    write_reg(sne_pkg::REG_THR_HIGH, 32'(thr_high));
  endtask

  // mostly frames of consecutive bins repeated so the per-bin history builds up,
  // with quiet, speech-like and silent frames; the rest is scattered noise items
  task automatic queue_random(input int count);
    int added, start, len, frames;
    longint base_pwr, pw;
    logic speech, silent;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 15) begin
        add_item(10'($urandom_range(1023)), $urandom, 1'($urandom_range(1)));
        added++;
      end else begin
        // frames often straddle a band edge
        case ($urandom_range(2))
          0: start = $urandom_range(NUM_BINS - 1);
          1: start = int'(cfg_low_last) - int'($urandom_range(4));
          default: start = int'(cfg_high_first) - int'($urandom_range(4));
        endcase
        if (start < 0) start = 0;
        // short frames revisit a bin while its update is still in flight
        len = $urandom_range(2, 12);
        frames = $urandom_range(3, 8);
        base_pwr = longint'($urandom_range(32'h0000_0100, 32'h0400_0000));
        if ($urandom_range(7) == 0) base_pwr = longint'($urandom_range(3));
        for (int f = 0; f < frames; f++) begin
          speech = ($urandom_range(3) == 0);
          silent = ($urandom_range(9) == 0);
          for (int b = 0; b < len; b++) begin
            pw = base_pwr + $urandom_range(32'(base_pwr / 4));
            if (speech) pw = pw * $urandom_range(4, 40);
            if (pw > PWR_MAX) pw = PWR_MAX;
            if (silent) pw = 0;
            add_item(10'(start + b), 32'(pw), b == len - 1);
          end
          added += len;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BINS; i++) begin
      smooth_mem[i] = '0;
      minimum_mem[i] = '0;
      presence_mem[i] = '0;
      noise_mem[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset band settings, sender and receiver both idle often
    send_gap_pct = 35;
    recv_stall_pct = 53;
    add_item(10'd0, 32'h0000_0000, 1'b0);
    add_item(10'd1, 32'hFFFF_FFFF, 1'b0);
    // sharp drop right after a peak on the same bin
    add_item(10'd1, 32'h0000_0000, 1'b0);
    // both sides of each band edge
    add_item(10'd43, 32'h0001_0000, 1'b0);
    add_item(10'd44, 32'h0001_0000, 1'b0);
    add_item(10'd127, 32'h0001_0000, 1'b0);
    add_item(10'd128, 32'h0001_0000, 1'b0);
    add_item(10'(NUM_BINS - 1), 32'hFFFF_FFFF, 1'b1);
    // top bins, the last one revisited at full scale right behind itself
    add_item(10'd1022, 32'h1234_5678, 1'b0);
    add_item(10'd1023, 32'hFFFF_FFFF, 1'b1);
    add_item(10'd1023, 32'hFFFF_FFFF, 1'b0);
    // steady floor on one bin, a burst, then back to the floor
    repeat (5) add_item(10'd5, 32'h0010_0000, 1'b0);
    repeat (3) add_item(10'd5, 32'h0400_0000, 1'b0);
    repeat (2) add_item(10'd5, 32'h0010_0000, 1'b1);
    queue_random(110);
    wait_drained();

    // every bin in the high band; a write to an unused address must change nothing
    write_reg(UNMAPPED_REG, 32'h0000_0000);
    set_bands(10'd1023, 10'd0, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_random(125);
    wait_drained();

    // bin 0 alone in the low band, bin 1023 alone in the high band
    send_gap_pct = 53;
    recv_stall_pct = 35;
    set_bands(10'd0, 10'd1023, 16'hFFFF, 16'h0000, 16'hFFFF);
    queue_random(125);
    wait_drained();

    // ordinary random bands and thresholds, full throughput
    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_bands(10'($urandom_range(200)), 10'($urandom_range(200, 600)),
              16'($urandom_range(256, 1024)), 16'($urandom_range(256, 1024)),
              16'($urandom_range(256, 1024)));
    queue_random(125);
    wait_drained();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
